// ===== rtl/cll_pkg.sv =====
// Shared types and constants for the clipped line rasterizer.
// Used by cll_div, cll_walk and clipped_line_rasterizer; depends on nothing.
package cll_pkg;

	localparam int COORD_W = 24;   // input coordinate width
	localparam int DEN_W   = 25;   // major-axis span, unsigned
	localparam int QUO_W   = 17;   // slope magnitude bits, up to 1.0 in Q.16
	localparam int CNT_W   = $clog2(QUO_W);
	localparam int SLOPE_W = QUO_W + 1;
	localparam int OFS_W   = 25;   // offset of the major position from its start
	localparam int ACC_W   = 43;   // slope times offset
	localparam int SLOPE_FRAC = 16;
	localparam int POS_W   = 28;   // pixel position before clipping
	localparam int LIM_W   = 32;   // screen limit in fixed point
	localparam int PIX_W   = 10;
	localparam int RGB_W   = 24;

	localparam int DEF_SCREEN_WIDTH    = 1024;
	localparam int DEF_SCREEN_HEIGHT   = 1024;
	localparam int DEF_COORD_FRAC_BITS = 8;
	localparam logic [RGB_W-1:0] COLOR_RESET = 24'hFFFFFF;

	typedef enum logic [0:0] {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} op_t;

	typedef struct packed {
		op_t                        opcode;
		logic signed [COORD_W-1:0]  first_x;
		logic signed [COORD_W-1:0]  first_y;
		logic signed [COORD_W-1:0]  second_x;
		logic signed [COORD_W-1:0]  second_y;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
		logic [RGB_W-1:0] pixel_rgb;
		logic             line_done;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP_A,
		ST_PREP_B,
		ST_DIV_GO,
		ST_DIV_RUN,
		ST_STEP_A,
		ST_STEP_B
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DEN_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic commit;
	} walk_ctl_t;

	typedef struct packed {
		logic                       major_is_x;
		logic signed [COORD_W-1:0]  major_start;
		logic signed [COORD_W-1:0]  minor_start;
		logic [DEN_W-1:0]           den;
		logic signed [SLOPE_W-1:0]  slope;
	} line_t;

endpackage

// ===== rtl/clipped_line_rasterizer.sv =====
// Clipped line rasterizer top level: handshakes, sequencer, color register.
// Load item: ready again only after PREP_A, PREP_B, the divider start, the
// divider iterations and the line install; it gives no result.
// Step item: two-stage evaluate/clip walk in STEP_A and STEP_B; the result is
// registered when the output is free. Async reset: no line, color white.
module clipped_line_rasterizer import cll_pkg::*; #(
	parameter int SCREEN_WIDTH    = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT   = DEF_SCREEN_HEIGHT,
	parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  in_item_t         req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output out_item_t        rsp,
	input  logic             cfg_we,
	input  logic [RGB_W-1:0] cfg_wdata
);

	state_t state_q, state_d;

	in_item_t                  ld_q;
	logic                      mx_q;
	logic signed [COORD_W-1:0] ld_start_q;
	logic signed [COORD_W-1:0] ld_minor_q;
	logic [DEN_W-1:0]          ld_den_q;
	logic [DEN_W-1:0]          ld_mag_q;
	logic                      ld_neg_q;
	logic [RGB_W-1:0]          color_q;
	logic                      rsp_valid_q;
	out_item_t                 rsp_q;

	div_req_t  div_req;
	div_rsp_t  div_rsp;
	walk_ctl_t walk_ctl;
	line_t     line;
	out_item_t walk_res;

	logic                      accept;
	logic                      out_free;
	logic signed [DEN_W-1:0]   dx, dy;
	logic [DEN_W-1:0]          adx, ady;
	logic signed [COORD_W-1:0] a1, b1, a2, b2;
	logic signed [COORD_W-1:0] as_c, ae_c, bs_c, be_c;
	logic                      keep;
	logic signed [DEN_W-1:0]   db;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// major axis choice
	always_comb begin
		dx  = DEN_W'(ld_q.second_x) - DEN_W'(ld_q.first_x);
		dy  = DEN_W'(ld_q.second_y) - DEN_W'(ld_q.first_y);
		adx = dx[DEN_W-1] ? DEN_W'(-dx) : DEN_W'(dx);
		ady = dy[DEN_W-1] ? DEN_W'(-dy) : DEN_W'(dy);
	end

	// endpoint ordering and spans
	always_comb begin
		a1   = mx_q ? ld_q.first_x  : ld_q.first_y;
		b1   = mx_q ? ld_q.first_y  : ld_q.first_x;
		a2   = mx_q ? ld_q.second_x : ld_q.second_y;
		b2   = mx_q ? ld_q.second_y : ld_q.second_x;
		keep = a1 < a2;
		as_c = keep ? a1 : a2;
		ae_c = keep ? a2 : a1;
		bs_c = keep ? b1 : b2;
		be_c = keep ? b2 : b1;
		db   = DEN_W'(be_c) - DEN_W'(bs_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = ld_mag_q;
		div_req.divisor  = ld_den_q;
		walk_ctl         = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (req.opcode == OP_LOAD) ? ST_PREP_A : ST_STEP_A;
				end
			end
			ST_PREP_A: state_d = ST_PREP_B;
			ST_PREP_B: state_d = ST_DIV_GO;
			ST_DIV_GO: begin
				div_req.start = 1'b1;
				state_d       = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				if (div_rsp.done) begin
					walk_ctl.load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_STEP_A: begin
				walk_ctl.eval = 1'b1;
				state_d       = ST_STEP_B;
			end
			ST_STEP_B: begin
				// hold until the output register can take the item
				if (out_free) begin
					walk_ctl.commit = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		line.major_is_x  = mx_q;
		line.major_start = ld_start_q;
		line.minor_start = ld_minor_q;
		line.den         = ld_den_q;
		line.slope       = ld_neg_q ? -SLOPE_W'(div_rsp.quotient)
		                            : SLOPE_W'(div_rsp.quotient);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ld_q <= req;
		end
		if (state_q == ST_PREP_A) begin
			mx_q <= ady < adx;
		end
		if (state_q == ST_PREP_B) begin
			ld_start_q <= as_c;
			ld_minor_q <= bs_c;
			ld_den_q   <= DEN_W'(ae_c) - DEN_W'(as_c);
			ld_neg_q   <= db[DEN_W-1];
			ld_mag_q   <= db[DEN_W-1] ? DEN_W'(-db) : DEN_W'(db);
		end
		if (walk_ctl.commit) begin
			rsp_q <= walk_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			color_q     <= COLOR_RESET;
		end else begin
			if (walk_ctl.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
		end
	end

	cll_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	cll_walk #(
		.SCREEN_WIDTH    (SCREEN_WIDTH),
		.SCREEN_HEIGHT   (SCREEN_HEIGHT),
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (walk_ctl),
		.line   (line),
		.color  (color_q),
		.res    (walk_res)
	);

`ifndef ASSERT_OFF
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV_RUN) else $error("divider result unexpected");
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		walk_ctl.commit |=> rsp_valid_q) else $error("step result lost");
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.line_done |-> rsp_q.pixel_x == '0 && rsp_q.pixel_y == '0
		&& rsp_q.pixel_rgb == '0) else $error("done item carries pixel data");
`endif

endmodule

// ===== rtl/cll_div.sv =====
// Serial restoring divider: one quotient bit per cycle, Q.16 slope magnitude.
// Depends on cll_pkg. Expects dividend <= divisor; a zero divisor gives zero.
module cll_div import cll_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             zero_q;

	logic [DEN_W+1:0] trial;
	logic             qbit;
	logic [DEN_W:0]   rem_next;

	always_comb begin
		trial    = {1'b0, rem_q} - {2'b00, den_q};
		qbit     = ~trial[DEN_W+1];
		rem_next = qbit ? trial[DEN_W:0] : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= {1'b0, req.dividend};
			den_q  <= req.divisor;
			quo_q  <= '0;
			zero_q <= (req.divisor == '0);
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top bit never drops out
			rem_q <= {rem_next[DEN_W-1:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], qbit};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = zero_q ? '0 : quo_q;

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held");
	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q)) else $error("divider busy and done together");
`endif

endmodule

// ===== rtl/cll_walk.sv =====
// Line walker: holds the loaded line, evaluates the next point, clips it.
// Depends on cll_pkg. Minor offset is an accumulator of slope per major step.
module cll_walk import cll_pkg::*; #(
	parameter int SCREEN_WIDTH    = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT   = DEF_SCREEN_HEIGHT,
	parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  walk_ctl_t        ctl,
	input  line_t            line,
	input  logic [RGB_W-1:0] color,
	output out_item_t        res
);

	localparam logic signed [LIM_W-1:0] W_LIM = LIM_W'(SCREEN_WIDTH) <<< COORD_FRAC_BITS;
	localparam logic signed [LIM_W-1:0] H_LIM = LIM_W'(SCREEN_HEIGHT) <<< COORD_FRAC_BITS;
	localparam logic [OFS_W-1:0]        ONE   = OFS_W'(1) << COORD_FRAC_BITS;

	logic                      active_q;
	logic                      mx_q;
	logic signed [COORD_W-1:0] start_q;
	logic signed [COORD_W-1:0] minor_q;
	logic [DEN_W-1:0]          den_q;
	logic signed [SLOPE_W-1:0] slope_q;
	logic [OFS_W-1:0]          ofs_q;
	logic signed [ACC_W-1:0]   acc_q;

	logic                      run_s1;
	logic signed [POS_W-1:0]   px_s1;
	logic signed [POS_W-1:0]   py_s1;

	logic signed [POS_W-1:0]   major_pos;
	logic signed [POS_W-1:0]   minor_pos;
	logic signed [LIM_W-1:0]   px_w;
	logic signed [LIM_W-1:0]   py_w;
	logic                      in_screen;
	logic                      emit;
	logic signed [ACC_W-1:0]   acc_inc;

	always_comb begin
		major_pos = POS_W'(start_q) + POS_W'(signed'({1'b0, ofs_q}));
		minor_pos = POS_W'(minor_q) + POS_W'(signed'(acc_q[ACC_W-1:SLOPE_FRAC]));
		acc_inc   = ACC_W'(slope_q) <<< COORD_FRAC_BITS;
	end

	// first half of a step: position and end test
	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			run_s1 <= active_q && (ofs_q < den_q);
			px_s1  <= mx_q ? major_pos : minor_pos;
			py_s1  <= mx_q ? minor_pos : major_pos;
		end
	end

	// second half: clip against the open screen rectangle
	always_comb begin
		px_w      = LIM_W'(px_s1);
		py_w      = LIM_W'(py_s1);
		in_screen = (px_w > 0) && (py_w > 0) && (px_w < W_LIM) && (py_w < H_LIM);
		emit      = run_s1 && in_screen;
		if (emit) begin
			res.pixel_x   = px_s1[COORD_FRAC_BITS +: PIX_W];
			res.pixel_y   = py_s1[COORD_FRAC_BITS +: PIX_W];
			res.pixel_rgb = color;
			res.line_done = 1'b0;
		end else begin
			res.pixel_x   = '0;
			res.pixel_y   = '0;
			res.pixel_rgb = '0;
			res.line_done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (ctl.load) begin
			active_q <= 1'b1;
		end else if (ctl.commit && !emit) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mx_q    <= line.major_is_x;
			start_q <= line.major_start;
			minor_q <= line.minor_start;
			den_q   <= line.den;
			slope_q <= line.slope;
			ofs_q   <= '0;
			acc_q   <= '0;
		end else if (ctl.commit && emit) begin
			// advance one whole pixel along the major axis
			ofs_q <= ofs_q + ONE;
			acc_q <= acc_q + acc_inc;
		end
	end

`ifndef ASSERT_OFF
	a_ctl_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(ctl)) else $error("walker controls overlap");
	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> active_q && ofs_q == '0) else $error("load did not restart line");
	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit && !$past(active_q) |-> res.line_done)
		else $error("pixel emitted without a line");
`endif

endmodule
